>>> hw/rtl/rmeu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Register machine execute unit package
// Opcodes, status codes, shared widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rmeu_pkg;

	localparam int DEF_MEM_BYTES = 1024;

	localparam logic [3:0] NO_INDEX = 4'hF;

	// two-byte forms
	localparam logic [7:0] OP_AR = 8'h10;
	localparam logic [7:0] OP_SR = 8'h12;
	localparam logic [7:0] OP_MR = 8'h14;
	localparam logic [7:0] OP_DR = 8'h16;
	localparam logic [7:0] OP_CR = 8'h18;
	localparam logic [7:0] OP_LR = 8'h31;
	// four-byte forms (GRP_RR marks the two-byte register group)
	localparam logic [3:0] GRP_RR = 4'h1;
	localparam logic [3:0] GRP_D  = 4'hD;
	localparam logic [3:0] LO_A   = 4'h1;
	localparam logic [3:0] LO_S   = 4'h3;
	localparam logic [3:0] LO_M   = 4'h5;
	localparam logic [3:0] LO_D   = 4'h7;
	localparam logic [3:0] LO_C   = 4'h9;
	localparam logic [7:0] OP_J   = 8'hE0;
	localparam logic [7:0] OP_JZ  = 8'hE1;
	localparam logic [7:0] OP_JP  = 8'hE2;
	localparam logic [7:0] OP_JN  = 8'hE3;
	localparam logic [7:0] OP_L   = 8'hF0;
	localparam logic [7:0] OP_LA  = 8'hF2;
	localparam logic [7:0] OP_ST  = 8'hF3;

	// arithmetic kind, from opcode bits 2:1
	localparam logic [1:0] K_ADD = 2'd0;
	localparam logic [1:0] K_SUB = 2'd1;
	localparam logic [1:0] K_MUL = 2'd2;
	localparam logic [1:0] K_DIV = 2'd3;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIV0  = 2'd1;
	localparam logic [1:0] ERR_BOUND = 2'd2;
	localparam logic [1:0] ERR_OVF   = 2'd3;

	localparam logic [1:0] CND_ZERO = 2'b00;
	localparam logic [1:0] CND_POS  = 2'b01;
	localparam logic [1:0] CND_NEG  = 2'b11;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic capture;
		logic calc_ea;
		logic mem_rd;
		logic exec;
		logic mul_fin;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic mul_go;
		logic div_go;
		logic div_done;
		logic out_free;
	} sts_t;

	// result beat, last member in the lowest bits
	typedef struct packed {
		logic [31:0] mem_value;
		logic [9:0]  mem_addr;
		logic        mem_written;
		logic [31:0] reg_value;
		logic [3:0]  reg_index;
		logic        reg_written;
		logic        halted;
		logic [1:0]  error;
		logic [1:0]  cond;
		logic [15:0] next_pc;
	} result_t;

	function automatic logic [1:0] sign32(input logic [31:0] v);
		if (v == 32'd0) return CND_ZERO;
		return v[31] ? CND_NEG : CND_POS;
	endfunction

	function automatic logic [1:0] sign33(input logic [32:0] v);
		if (v == 33'd0) return CND_ZERO;
		return v[32] ? CND_NEG : CND_POS;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/register_machine_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Register machine execute unit
// Executes one instruction or preloads one data word per input beat.
// ----------------------------------------------------------------------------
// Input beat (s_*): tuser[0] selects preload (0) or execute at pc (1); tdata
// carries the instruction, preload word index and preload data. Each input
// beat yields exactly one result beat (m_*) with the next pc, condition,
// sticky error, halt flag and any register write or word store.
// program_length is set through cfg_wr_en/cfg_wr_data; the user must write it
// only while the unit is idle, the unit itself does not enforce this. One beat
// at a time: accept, address, memory read, execute, commit. A multiply adds a
// finish step before commit, and a divide waits for the radix-2 divider,
// which produces one quotient bit per cycle.
// The result sits in an output register, so the next beat is accepted while
// it waits; if the receiver still stalls at commit time, the unit holds there.
// Reset clears registers, pc, condition, error and program length; data
// memory holds nothing defined until preloaded or stored.
// ----------------------------------------------------------------------------
module register_machine_execute_unit
	import rmeu_pkg::*;
#(
	parameter int MEM_BYTES = DEF_MEM_BYTES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// instr[31:0], load_word_index[39:32], load_data[71:40]
	input  wire logic [71:0]  s_tdata,
	// op[0]
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// next_pc[15:0], cond[17:16], error[19:18], halted[20], reg_written[21],
	// reg_index[25:22], reg_value[57:26], mem_written[58], mem_addr[68:59],
	// mem_value[100:69], zero fill[103:101]
	output logic [103:0]      m_tdata,
	input  wire logic         cfg_wr_en,
	input  wire logic [15:0]  cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	rmeu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmeu_datapath #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule
`default_nettype wire

>>> hw/rtl/rmeu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed divider
// Radix-2 restoring division, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rmeu_div
	import rmeu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31] ^ divisor[31];
			quo_q <= dividend[31] ? -dividend : dividend;
			dvs_q <= divisor[31] ? -divisor : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/rmeu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Execute unit datapath
// Register file, banked data memory, ALU, multiplier, divider, result register.
// ----------------------------------------------------------------------------
module rmeu_datapath
	import rmeu_pkg::*;
#(
	parameter int MEM_BYTES = DEF_MEM_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [71:0] s_tdata,
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [103:0]     m_tdata,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	localparam int AW   = $clog2(MEM_BYTES);
	localparam int RW   = AW - 2;
	localparam int ROWS = (MEM_BYTES + 3) / 4;
	localparam logic [32:0] EA_MAX   = 33'(MEM_BYTES - 4);
	localparam logic [16:0] LD_ROWS  = 17'(MEM_BYTES / 4);

	// captured beat
	logic        op_q;
	logic [31:0] instr_q;
	logic [7:0]  lwi_q;
	logic [31:0] ldata_q;

	// architectural state
	logic [15:0] plen_q;
	logic [15:0] pc_q;
	logic [1:0]  cond_q;
	logic [1:0]  sticky_q;
	logic [31:0] rf_q [16];
	logic [15:0] rf_v_q;
	logic [31:0] ra_q, rb_q;
	logic        ra_v_q, rb_v_q;

	logic [32:0] ea_q;
	logic        ok_q;
	logic [7:0]  bank_rd [4];

	// pending outcome of the step
	logic [1:0]  p_err_q;
	logic        p_wr_q;
	logic [31:0] p_val_q;
	logic        p_cupd_q;
	logic [1:0]  p_cond_q;
	logic        p_st_q;
	logic [63:0] prod_s2;

	result_t     out_q;
	logic        out_vld_q;

	// decode
	logic [7:0]  b0;
	logic [3:0]  r1, r2;
	logic [15:0] disp;
	logic [31:0] a, b, mw, bo;
	logic        two, halted_now, active, arith_op, is_d, need_ok, bad_addr;
	logic [1:0]  kind;
	logic        take;
	logic [15:0] npc;
	logic [32:0] addsub, diff, ea_nxt;
	logic        div_go, mul_go;
	logic        div_done;
	logic [31:0] div_q;
	logic [1:0]  ea_lo;
	logic [RW-1:0] ea_row;
	logic [16:0] lwi_x;
	logic        pre_wr, st_wr;

	assign b0   = instr_q[31:24];
	assign r1   = instr_q[23:20];
	assign r2   = instr_q[19:16];
	assign disp = instr_q[15:0];
	assign a    = ra_v_q ? ra_q : '0;
	assign b    = rb_v_q ? rb_q : '0;

	assign ea_lo  = ea_q[1:0];
	assign ea_row = ea_q[AW-1:2];
	assign lwi_x  = {9'd0, lwi_q};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mw[31-8*k -: 8] = bank_rd[2'(ea_lo + 2'(k))];
		end
	end

	assign two        = (b0[7:4] == GRP_RR) || (b0 == OP_LR);
	assign halted_now = (sticky_q != ERR_NONE) || ({1'b0, pc_q} + 17'd2 > {1'b0, plen_q});
	assign active     = op_q && !halted_now;
	assign is_d       = !two && (b0[7:4] == GRP_D);
	assign need_ok    = is_d || (b0 == OP_L) || (b0 == OP_ST);
	assign bad_addr   = need_ok && !ok_q;
	assign bo         = two ? b : mw;
	assign kind       = b0[2:1];
	assign arith_op   = two ? (b0 == OP_AR || b0 == OP_SR || b0 == OP_MR || b0 == OP_DR)
	                        : (is_d && (b0[3:0] == LO_A || b0[3:0] == LO_S ||
	                                    b0[3:0] == LO_M || b0[3:0] == LO_D));
	assign addsub     = (kind == K_SUB) ? ({a[31], a} - {bo[31], bo})
	                                    : ({a[31], a} + {bo[31], bo});
	assign diff       = {a[31], a} - {bo[31], bo};
	assign mul_go     = active && arith_op && (kind == K_MUL) && !bad_addr;
	assign div_go     = active && arith_op && (kind == K_DIV) && !bad_addr &&
	                    (bo != 32'd0) && !(a == INT_MIN && bo == '1);
	assign take       = (b0 == OP_J) || (b0 == OP_JZ && cond_q == CND_ZERO) ||
	                    (b0 == OP_JP && cond_q == CND_POS) || (b0 == OP_JN && cond_q == CND_NEG);
	assign npc        = two ? pc_q + 16'd2
	                        : ((b0 == OP_J || b0 == OP_JZ || b0 == OP_JP || b0 == OP_JN) && take)
	                          ? disp : pc_q + 16'd4;
	assign ea_nxt     = {{17{disp[15]}}, disp} + ((r2 != NO_INDEX) ? {b[31], b} : 33'd0);

	assign pre_wr = cmd.calc_ea && !op_q && (lwi_x < LD_ROWS);
	assign st_wr  = cmd.commit && active && (p_err_q == ERR_NONE) && p_st_q;

	// ---- data memory: four byte banks, an unaligned word touches each once ----
	for (genvar j = 0; j < 4; j++) begin : g_bank
		logic [7:0]    mem [ROWS];
		logic [7:0]    rd_q;
		logic [RW-1:0] row;
		logic [1:0]    k;
		logic          wen;
		logic [RW-1:0] waddr;
		logic [7:0]    wdata;

		assign row = ea_row + RW'(2'(j) < ea_lo);
		assign k   = 2'(j) - ea_lo;

		always_comb begin
			wen   = pre_wr || st_wr;
			waddr = pre_wr ? lwi_x[RW-1:0] : row;
			wdata = pre_wr ? ldata_q[31-8*j -: 8] : a[31 - 8*k -: 8];
		end

		always_ff @(posedge clk) begin
			if (wen) mem[waddr] <= wdata;
			if (cmd.mem_rd) rd_q <= mem[row];
		end

		assign bank_rd[j] = rd_q;
	end

	rmeu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && div_go),
		.dividend (a),
		.divisor  (bo),
		.done     (div_done),
		.quotient (div_q)
	);

	// ---- capture, register read, address, register write ----
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= s_tuser[0];
			instr_q <= s_tdata[31:0];
			lwi_q   <= s_tdata[39:32];
			ldata_q <= s_tdata[71:40];
			ra_q    <= rf_q[s_tdata[23:20]];
			rb_q    <= rf_q[s_tdata[19:16]];
			ra_v_q  <= rf_v_q[s_tdata[23:20]];
			rb_v_q  <= rf_v_q[s_tdata[19:16]];
		end
		if (cmd.calc_ea) begin
			ea_q <= ea_nxt;
			ok_q <= !ea_nxt[32] && (ea_nxt <= EA_MAX);
		end
		if (st_wr == 1'b0 && cmd.commit && active && p_err_q == ERR_NONE && p_wr_q) begin
			rf_q[r1] <= p_val_q;
		end
	end

	// ---- execute ----
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			p_err_q  <= ERR_NONE;
			p_wr_q   <= 1'b0;
			p_val_q  <= '0;
			p_cupd_q <= 1'b0;
			p_cond_q <= CND_ZERO;
			p_st_q   <= 1'b0;
			prod_s2  <= $signed(a) * $signed(bo);
			if (active) begin
				if (bad_addr) begin
					p_err_q <= ERR_BOUND;
				end else if (arith_op) begin
					p_cupd_q <= two;
					unique case (kind)
						K_ADD, K_SUB: begin
							if (addsub[32] != addsub[31]) begin
								p_err_q <= ERR_OVF;
							end else begin
								p_wr_q   <= 1'b1;
								p_val_q  <= addsub[31:0];
								p_cond_q <= sign32(addsub[31:0]);
							end
						end
						K_MUL: ;
						K_DIV: begin
							if (bo == 32'd0) p_err_q <= ERR_DIV0;
							else if (!div_go) p_err_q <= ERR_OVF;
						end
						default: ;
					endcase
				end else if (b0 == OP_LR) begin
					p_wr_q  <= 1'b1;
					p_val_q <= b;
				end else if (b0 == OP_CR || (is_d && b0[3:0] == LO_C)) begin
					p_cupd_q <= 1'b1;
					p_cond_q <= sign33(diff);
				end else if (b0 == OP_L) begin
					p_wr_q  <= 1'b1;
					p_val_q <= mw;
				end else if (b0 == OP_LA && !two) begin
					p_wr_q  <= 1'b1;
					p_val_q <= {{16{disp[15]}}, disp};
				end else if (b0 == OP_ST) begin
					p_st_q <= 1'b1;
				end
			end
		end else if (cmd.mul_fin) begin
			if (prod_s2[63:31] != '0 && prod_s2[63:31] != '1) begin
				p_err_q <= ERR_OVF;
			end else begin
				p_wr_q   <= 1'b1;
				p_val_q  <= prod_s2[31:0];
				p_cond_q <= sign32(prod_s2[31:0]);
			end
		end else if (div_done) begin
			p_wr_q   <= 1'b1;
			p_val_q  <= div_q;
			p_cond_q <= sign32(div_q);
		end
	end

	// ---- commit and result ----
	logic        ok_commit;
	logic [1:0]  new_err;
	logic [15:0] new_pc;
	logic [1:0]  new_cond;

	assign ok_commit = active && (p_err_q == ERR_NONE);
	assign new_err   = (active && p_err_q != ERR_NONE) ? p_err_q : sticky_q;
	assign new_pc    = ok_commit ? npc : pc_q;
	assign new_cond  = (ok_commit && p_cupd_q) ? p_cond_q : cond_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			pc_q      <= '0;
			cond_q    <= CND_ZERO;
			sticky_q  <= ERR_NONE;
			rf_v_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) plen_q <= cfg_wr_data;
			if (cmd.commit) begin
				pc_q      <= new_pc;
				cond_q    <= new_cond;
				sticky_q  <= new_err;
				out_vld_q <= 1'b1;
				if (ok_commit && p_wr_q) rf_v_q[r1] <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.next_pc     <= new_pc;
			out_q.cond        <= new_cond;
			out_q.error       <= new_err;
			out_q.halted      <= (new_err != ERR_NONE) ||
			                     ({1'b0, new_pc} + 17'd2 > {1'b0, plen_q});
			out_q.reg_written <= ok_commit && p_wr_q;
			out_q.reg_index   <= (ok_commit && p_wr_q) ? r1 : '0;
			out_q.reg_value   <= (ok_commit && p_wr_q) ? p_val_q : '0;
			out_q.mem_written <= ok_commit && p_st_q;
			out_q.mem_addr    <= (ok_commit && p_st_q) ? ea_q[9:0] : '0;
			out_q.mem_value   <= (ok_commit && p_st_q) ? a : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'd0, out_q};

	assign sts.mul_go   = mul_go;
	assign sts.div_go   = div_go;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_vld_q || m_tready;

	// never overwrite a result beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_vld_q || m_tready))
		else $error("result overwritten while stalled");

	// a fault stays latched
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE) |=> (sticky_q != ERR_NONE))
		else $error("sticky error cleared");

	// a step never both writes a register and stores a word
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(p_wr_q && p_st_q))
		else $error("register write and store in one step");

endmodule
`default_nettype wire

>>> hw/rtl/rmeu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Execute unit controller
// Sequences capture, address, memory read, execute, multiply/divide, commit.
// ----------------------------------------------------------------------------
module rmeu_ctrl
	import rmeu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EA   = 3'd1;
	localparam logic [2:0] S_MRD  = 3'd2;
	localparam logic [2:0] S_EX   = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_WB   = 3'd6;

	logic [2:0] state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_nxt = S_EA;
			S_EA:   state_nxt = S_MRD;
			S_MRD:  state_nxt = S_EX;
			S_EX: begin
				priority if (sts.mul_go) state_nxt = S_MUL;
				else if (sts.div_go) state_nxt = S_DIV;
				else state_nxt = S_WB;
			end
			S_MUL:  state_nxt = S_WB;
			S_DIV:  if (sts.div_done) state_nxt = S_WB;
			S_WB:   if (sts.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	assign s_tready    = (state_q == S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && s_tvalid;
	assign cmd.calc_ea = (state_q == S_EA);
	assign cmd.mem_rd  = (state_q == S_MRD);
	assign cmd.exec    = (state_q == S_EX);
	assign cmd.mul_fin = (state_q == S_MUL);
	// hold the commit until the result register can take the beat
	assign cmd.commit  = (state_q == S_WB) && sts.out_free;

endmodule
`default_nettype wire

>>> tb/register_machine_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register machine execute unit testbench
// Fills data memory, then runs directed and random instruction streams
// over several program lengths and checks every result beat against a
// cycle-free model of the machine. One fault is provoked at the very end,
// since the error is sticky for the rest of the run.
// ----------------------------------------------------------------------------
module register_machine_execute_unit_tb;
	import rmeu_pkg::*;

	localparam int MEMB = DEF_MEM_BYTES;

	class exec_scoreboard;
		logic [31:0] regs [16];
		logic [7:0]  mem [MEMB];
		logic [1:0]  cnd;
		logic [15:0] pc;
		logic [1:0]  serr;
		logic [15:0] plen;
		result_t     expq [$];
		int          mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			cnd = CND_ZERO;
			pc = '0;
			serr = ERR_NONE;
			plen = '0;
			mismatches = 0;
		endfunction

		function bit stopped(logic [1:0] e, logic [15:0] p);
			return e != ERR_NONE || {1'b0, p} + 17'd2 > {1'b0, plen};
		endfunction

		function logic [31:0] rd_word(int a);
			return {mem[a], mem[a + 1], mem[a + 2], mem[a + 3]};
		endfunction

		function logic [1:0] sgn(longint v);
			if (v == 0) return CND_ZERO;
			return v < 0 ? CND_NEG : CND_POS;
		endfunction

		function logic [1:0] arith(logic [1:0] k, longint a, longint b, output longint r);
			r = 0;
			if (k == K_DIV) begin
				if (b == 0) return ERR_DIV0;
				if (a == -64'sd2147483648 && b == -1) return ERR_OVF;
				r = a / b;
			end else if (k == K_MUL) begin
				r = a * b;
			end else if (k == K_SUB) begin
				r = a - b;
			end else begin
				r = a + b;
			end
			if (r > 64'sd2147483647 || r < -64'sd2147483648) return ERR_OVF;
			return ERR_NONE;
		endfunction

		// compute one step; commit state only when keep is set
		function result_t step(bit op, logic [31:0] ins, logic [7:0] idx,
				logic [31:0] dat, bit keep);
			result_t     r;
			logic [7:0]  b0;
			logic [3:0]  r1, r2;
			logic [1:0]  ncnd, err;
			logic [15:0] npc;
			logic [31:0] wval, sval;
			bit          wr, st, ok;
			longint      a, b, m, res, disp, ea;
			r = '0;
			b0 = ins[31:24];
			r1 = ins[23:20];
			r2 = ins[19:16];
			ncnd = cnd;
			npc = pc;
			err = ERR_NONE;
			wr = 0;
			st = 0;
			wval = '0;
			sval = '0;
			ea = 0;
			if (!op) begin
				if (keep)
					for (int k = 0; k < 4; k++) mem[idx * 4 + k] = dat[31 - 8 * k -: 8];
			end else if (!stopped(serr, pc)) begin
				a = longint'($signed(regs[r1]));
				if (b0[7:4] == GRP_RR || b0 == OP_LR) begin
					b = longint'($signed(regs[r2]));
					npc = pc + 16'd2;
					if (b0 == OP_LR) begin
						wr = 1;
						wval = regs[r2];
					end else if (b0 == OP_CR) begin
						ncnd = sgn(a - b);
					end else if (b0 == OP_AR || b0 == OP_SR || b0 == OP_MR || b0 == OP_DR) begin
						err = arith(b0[2:1], a, b, res);
						if (err == ERR_NONE) begin
							wr = 1;
							wval = res[31:0];
							ncnd = sgn(res);
						end
					end
				end else begin
					disp = longint'($signed(ins[15:0]));
					ea = disp + (r2 != NO_INDEX ? longint'($signed(regs[r2])) : 0);
					ok = ea >= 0 && ea <= MEMB - 4;
					npc = pc + 16'd4;
					if (b0[7:4] == GRP_D) begin
						if (!ok) begin
							err = ERR_BOUND;
						end else begin
							m = longint'($signed(rd_word(int'(ea))));
							if (b0[3:0] == LO_C) begin
								ncnd = sgn(a - m);
							end else if (b0[3:0] == LO_A || b0[3:0] == LO_S ||
									b0[3:0] == LO_M || b0[3:0] == LO_D) begin
								err = arith(b0[2:1], a, m, res);
								if (err == ERR_NONE) begin
									wr = 1;
									wval = res[31:0];
								end
							end
						end
					end else if (b0 == OP_J || (b0 == OP_JZ && cnd == CND_ZERO) ||
							(b0 == OP_JP && cnd == CND_POS) || (b0 == OP_JN && cnd == CND_NEG)) begin
						npc = ins[15:0];
					end else if (b0 == OP_L) begin
						if (!ok) err = ERR_BOUND;
						else begin
							wr = 1;
							wval = rd_word(int'(ea));
						end
					end else if (b0 == OP_LA) begin
						wr = 1;
						wval = disp[31:0];
					end else if (b0 == OP_ST) begin
						if (!ok) err = ERR_BOUND;
						else begin
							st = 1;
							sval = regs[r1];
						end
					end
				end
				if (err != ERR_NONE) begin
					wr = 0;
					st = 0;
					npc = pc;
				end
			end
			r.next_pc = npc;
			r.cond = ncnd;
			r.error = err != ERR_NONE ? err : serr;
			r.halted = stopped(r.error, npc);
			r.reg_written = wr;
			r.reg_index = wr ? r1 : '0;
			r.reg_value = wr ? wval : '0;
			r.mem_written = st;
			r.mem_addr = st ? ea[9:0] : '0;
			r.mem_value = st ? sval : '0;
			if (keep) begin
				if (wr) regs[r1] = wval;
				if (st) for (int k = 0; k < 4; k++) mem[int'(ea) + k] = sval[31 - 8 * k -: 8];
				cnd = ncnd;
				pc = npc;
				serr = r.error;
			end
			return r;
		endfunction

		function bit faults(logic [31:0] ins);
			result_t r;
			r = step(1'b1, ins, '0, '0, 0);
			return r.error != serr;
		endfunction

		function void note_input(bit op, logic [31:0] ins, logic [7:0] idx, logic [31:0] dat);
			expq.push_back(step(op, ins, idx, dat, 1));
		endfunction

		function void check_result(logic [103:0] beat);
			result_t got, want;
			got = result_t'(beat[100:0]);
			if (expq.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			want = expq.pop_front();
			if (got !== want || beat[103:101] !== 3'b000) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: pc %h/%h cond %h/%h err %h/%h halt %b/%b ",
						"rw %b/%b ri %h/%h rv %h/%h mw %b/%b ma %h/%h mv %h/%h (exp/act)"},
						want.next_pc, got.next_pc, want.cond, got.cond, want.error,
						got.error, want.halted, got.halted, want.reg_written,
						got.reg_written, want.reg_index, got.reg_index, want.reg_value,
						got.reg_value, want.mem_written, got.mem_written, want.mem_addr,
						got.mem_addr, want.mem_value, got.mem_value);
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [103:0] m_tdata;
	logic         cfg_wr_en = 0;
	logic [15:0]  cfg_wr_data = '0;

	exec_scoreboard sb = new();
	bit quiet = 0;

	register_machine_execute_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	function int gap();
		if (quiet || $urandom_range(0, 4) == 0) return 0;
		return $urandom_range(0, 12);
	endfunction

	task send(bit op, logic [31:0] ins, logic [7:0] idx, logic [31:0] dat);
		int n;
		n = gap();
		@(negedge clk);
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {dat, idx, ins};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.note_input(op, ins, idx, dat);
	endtask

	// execute, swapping a faulting instruction for a harmless LA
	task run_safe(logic [31:0] ins);
		if (sb.faults(ins)) ins = {OP_LA, ins[23:0]};
		send(1'b1, ins, 8'($urandom), $urandom);
	endtask

	task drain();
		@(negedge clk);
		s_tvalid <= 0;
		wait (sb.expq.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task set_length(logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
		sb.plen = v;
	endtask

	function logic [31:0] rand_exec();
		logic [7:0]  b0;
		logic [3:0]  r1, r2;
		logic [15:0] d;
		int          lim, sel;
		logic [7:0]  rr_ops [6] = '{OP_AR, OP_SR, OP_MR, OP_DR, OP_CR, OP_LR};
		logic [7:0]  mem_ops [8] = '{8'hD1, 8'hD3, 8'hD5, 8'hD7, 8'hD9, OP_L, OP_ST, 8'hD0};
		logic [7:0]  jmp_ops [4] = '{OP_J, OP_JZ, OP_JP, OP_JN};
		r1 = 4'($urandom);
		r2 = 4'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 8) return $urandom;
		if (sel < 18) begin
			lim = sb.plen > 8 ? (sb.plen < 2000 ? sb.plen - 4 : 1996) : 0;
			d = 16'($urandom_range(0, lim) & ~1);
			return {jmp_ops[$urandom_range(0, 3)], r1, r2, d};
		end
		if (sel < 30) return {OP_LA, r1, r2, 16'($urandom)};
		if (sel < 55) return {rr_ops[$urandom_range(0, 5)], r1, r2, 16'($urandom)};
		b0 = mem_ops[$urandom_range(0, 7)];
		if ($urandom_range(0, 1)) return {b0, r1, NO_INDEX, 16'($urandom_range(0, MEMB - 4))};
		return {b0, r1, r2, 16'($signed($urandom_range(0, 1100)) - 16'sd64)};
	endfunction

	initial begin
		int ph;
		logic [15:0] lens [5];
		logic [31:0] dir [$];
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// fill the whole data memory so no read ever sees an unwritten byte
		for (int w = 0; w < MEMB / 4; w++)
			send(1'b0, $urandom, 8'(w), w == 0 ? INT_MIN : w == 1 ? 32'h7FFF_FFFF :
				w == 2 ? 32'hFFFF_FFFF : w == 3 ? 32'h0 : $urandom);
		drain();
		set_length(16'hFFFF);

		dir = '{{OP_LA, 8'h1F, 16'hFFFF}, {OP_LA, 8'h2F, 16'h7FFF}, {OP_L, 8'h3F, 16'h0000},
			{OP_L, 8'h4F, 16'h0004}, {OP_L, 8'h5F, 16'h0008}, {OP_AR, 8'h12, 16'h0},
			{OP_SR, 8'h21, 16'h0}, {OP_MR, 8'h21, 16'h0}, {OP_DR, 8'h42, 16'h0},
			{OP_CR, 8'h34, 16'h0}, {OP_LR, 8'h63, 16'h0}, {8'hD1, 8'h1F, 16'h0004},
			{8'hD3, 8'h2F, 16'h0008}, {8'hD5, 8'h1F, 16'h0008}, {8'hD7, 8'h4F, 16'h0008},
			{8'hD9, 8'h3F, 16'h03FC}, {OP_ST, 8'h6F, 16'h03FC}, {OP_J, 8'hFF, 16'h0040},
			{OP_JZ, 8'h00, 16'h0080}, {OP_JP, 8'h00, 16'h0080}, {OP_JN, 8'h00, 16'h0080},
			{8'h11, 8'h00, 16'h0}, {8'h00, 8'h00, 16'h0}, {8'hD0, 8'h0F, 16'h0010},
			{OP_LA, 8'h7F, 16'h0100}, {OP_L, 8'h97, 16'hFFF0}};
		foreach (dir[i]) run_safe(dir[i]);
		drain();

		lens = '{16'hFFFF, 16'h0000, 16'($urandom_range(100, 3000)), 16'h0010, 16'hFFFF};
		for (ph = 0; ph < 5; ph++) begin
			set_length(lens[ph]);
			for (int i = 0; i < 300; i++) begin
				if (i % 60 == 0) quiet = $urandom_range(0, 3) == 0;
				if ($urandom_range(0, 6) == 0) send(1'b0, $urandom, 8'($urandom), $urandom);
				else run_safe(rand_exec());
			end
			quiet = 0;
			drain();
		end

		// one fault only: the error is sticky until reset
		case ($urandom_range(0, 3))
			0: begin
				run_safe({OP_LA, 8'h5F, 16'h0000});
				send(1'b1, {OP_DR, 8'h65, 16'h0}, '0, '0);
			end
			1: send(1'b1, {OP_L, 8'h1F, 16'h7FFF}, '0, '0);
			2: begin
				run_safe({OP_LA, 8'h7F, 16'h4000});
				run_safe({OP_MR, 8'h77, 16'h0});
				send(1'b1, {OP_MR, 8'h77, 16'h0}, '0, '0);
			end
			default: begin
				run_safe({OP_LA, 8'h8F, 16'hFFFF});
				run_safe({OP_LA, 8'h9F, 16'h8000});
				run_safe({OP_LA, 8'hAF, 16'hFFFE});
				run_safe({OP_MR, 8'h99, 16'h0});
				run_safe({OP_MR, 8'h9A, 16'h0});
				send(1'b1, {OP_DR, 8'h98, 16'h0}, '0, '0);
			end
		endcase
		for (int i = 0; i < 6; i++) send(1'b1, rand_exec(), 8'($urandom), $urandom);
		send(1'b0, $urandom, 8'($urandom), $urandom);
		drain();

		if (sb.mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		int n;
		forever begin
			n = gap();
			@(negedge clk);
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			sb.check_result(m_tdata);
		end
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
